/* rtl/adsp_pkg.sv */
// ----------------------------------------------------------------------------
// Audio DSP interface register package
// Operation codes, register offsets, bit positions and reset values shared by
// the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package adsp_pkg;

   // Operation codes of one input transaction.
   localparam logic [2:0] OP_READ16  = 3'd0;
   localparam logic [2:0] OP_WRITE16 = 3'd1;
   localparam logic [2:0] OP_READ32  = 3'd2;
   localparam logic [2:0] OP_WRITE32 = 3'd3;
   localparam logic [2:0] OP_TICK    = 3'd4;
   localparam logic [2:0] OP_IRQ     = 3'd5;

   // Interrupt event sources.
   localparam logic [1:0] SRC_DSP  = 2'd0;
   localparam logic [1:0] SRC_ARAM = 2'd1;
   localparam logic [1:0] SRC_AID  = 2'd2;

   // Register offsets (low 16 bits of the bus address).
   localparam logic [15:0] OFS_CONTROL    = 16'h500A;
   localparam logic [15:0] OFS_INFO       = 16'h5012;
   localparam logic [15:0] OFS_MODE       = 16'h5016;
   localparam logic [15:0] OFS_REFRESH    = 16'h501A;
   localparam logic [15:0] OFS_MAIN_HI    = 16'h5020;
   localparam logic [15:0] OFS_MAIN_LO    = 16'h5022;
   localparam logic [15:0] OFS_AUX_HI     = 16'h5024;
   localparam logic [15:0] OFS_AUX_LO     = 16'h5026;
   localparam logic [15:0] OFS_COUNT_HI   = 16'h5028;
   localparam logic [15:0] OFS_COUNT_LO   = 16'h502A;
   localparam logic [15:0] OFS_SOURCE_HI  = 16'h5030;
   localparam logic [15:0] OFS_SOURCE_LO  = 16'h5032;
   localparam logic [15:0] OFS_AUDIO_CTRL = 16'h5036;
   localparam logic [15:0] OFS_BLOCKS     = 16'h503A;

   // Control register bits.
   localparam int CTL_RESET     = 0;
   localparam int CTL_AID       = 3;
   localparam int CTL_AID_MASK  = 4;
   localparam int CTL_ARAM      = 5;
   localparam int CTL_ARAM_MASK = 6;
   localparam int CTL_DSP       = 7;
   localparam int CTL_DSP_MASK  = 8;
   localparam int CTL_DMA_BUSY  = 9;

   // Bits stored as written, and the write-1-to-clear flags.
   localparam logic [15:0] CTL_PLAIN_BITS = 16'hFD57;
   localparam logic [15:0] CTL_W1C_BITS   = 16'h00A8;

   // Address and count masks.
   localparam logic [31:0] ALIGN32_MASK = 32'hFFFF_FFE0;
   localparam logic [31:0] HI_HALF_MASK = 32'hFFFF_0000;
   localparam logic [31:0] BLOCK_BYTES  = 32'd32;
   localparam logic [30:0] SINGLE_BLOCK = 31'd32;

   // Configuration register index.
   localparam logic CFG_AUX_RAM_SIZE = 1'b0;

   // Reset values.
   localparam logic [15:0] CONTROL_RESET  = 16'h0004;
   localparam logic [15:0] INFO_RESET     = 16'h0000;
   localparam logic [15:0] MODE_RESET     = 16'h0001;
   localparam logic [15:0] REFRESH_RESET  = 16'd156;
   localparam logic [26:0] AUX_SIZE_RESET = 27'd16777216;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } adsp_cmd_type;

endpackage : adsp_pkg

`default_nettype wire

/* rtl/audio_dsp_interface_registers_unit.sv */
// ----------------------------------------------------------------------------
// Audio DSP interface registers, top level
// A transaction accepted in the idle state is captured, committed in the
// controller's execute state and then strobed on rsp_valid from a register;
// busy is high while it executes, and no new transaction is taken then.
// Reset: synchronous, active high; architectural registers take their documented values.
// Results are strobed for one cycle and the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_dsp_interface_registers_unit
   import adsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input transaction.
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [15:0] req_reg_offset,
   input  wire logic [31:0] req_write_data,
   input  wire logic [1:0]  req_irq_source,
   input  wire logic        req_irq_set,
   // Result transaction.
   output logic             rsp_valid,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_irq_line,
   output logic             rsp_dma_start,
   output logic             rsp_dma_to_main,
   output logic [25:0]      rsp_dma_main_addr,
   output logic [25:0]      rsp_dma_aux_addr,
   output logic [30:0]      rsp_dma_bytes,
   output logic             rsp_dma_in_range,
   output logic             rsp_audio_push,
   output logic             rsp_audio_silence,
   output logic [31:0]      rsp_audio_addr,
   output logic [17:0]      rsp_audio_samples,
   // Configuration port.
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   adsp_cmd_type cmd;
   logic         cfg_write;

   // A write completes in the access cycle; the port never waits.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   adsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   adsp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_operation     (req_operation),
      .req_reg_offset    (req_reg_offset),
      .req_write_data    (req_write_data),
      .req_irq_source    (req_irq_source),
      .req_irq_set       (req_irq_set),
      .cfg_write         (cfg_write),
      .cfg_index         (paddr[2]),
      .cfg_wdata         (pwdata),
      .cfg_rdata         (prdata),
      .rsp_read_data     (rsp_read_data),
      .rsp_irq_line      (rsp_irq_line),
      .rsp_dma_start     (rsp_dma_start),
      .rsp_dma_to_main   (rsp_dma_to_main),
      .rsp_dma_main_addr (rsp_dma_main_addr),
      .rsp_dma_aux_addr  (rsp_dma_aux_addr),
      .rsp_dma_bytes     (rsp_dma_bytes),
      .rsp_dma_in_range  (rsp_dma_in_range),
      .rsp_audio_push    (rsp_audio_push),
      .rsp_audio_silence (rsp_audio_silence),
      .rsp_audio_addr    (rsp_audio_addr),
      .rsp_audio_samples (rsp_audio_samples)
   );

endmodule : audio_dsp_interface_registers_unit

`default_nettype wire

/* rtl/adsp_ctrl.sv */
// ----------------------------------------------------------------------------
// Audio DSP interface controller
// Two-state sequencer: accepts a transaction, lets the datapath commit it in
// the following cycle and strobes the result in the cycle after the commit.
// ----------------------------------------------------------------------------
`default_nettype none

module adsp_ctrl
   import adsp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   output logic        busy,
   output logic        rsp_valid,
   output adsp_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // Commands follow the state directly.
   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && start;
      cmd.commit  = (state_ff == ST_EXEC);
   end

   // State and the result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule : adsp_ctrl

`default_nettype wire

/* rtl/adsp_datapath.sv */
// ----------------------------------------------------------------------------
// Audio DSP interface datapath
// Holds the interface registers, the configuration register and the result
// registers, and works out one transaction when the controller commits it.
// ----------------------------------------------------------------------------
`default_nettype none

module adsp_datapath
   import adsp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire adsp_cmd_type cmd,
   input  wire logic [2:0]   req_operation,
   input  wire logic [15:0]  req_reg_offset,
   input  wire logic [31:0]  req_write_data,
   input  wire logic [1:0]   req_irq_source,
   input  wire logic         req_irq_set,
   input  wire logic         cfg_write,
   input  wire logic         cfg_index,
   input  wire logic [31:0]  cfg_wdata,
   output logic [31:0]       cfg_rdata,
   output logic [31:0]       rsp_read_data,
   output logic              rsp_irq_line,
   output logic              rsp_dma_start,
   output logic              rsp_dma_to_main,
   output logic [25:0]       rsp_dma_main_addr,
   output logic [25:0]       rsp_dma_aux_addr,
   output logic [30:0]       rsp_dma_bytes,
   output logic              rsp_dma_in_range,
   output logic              rsp_audio_push,
   output logic              rsp_audio_silence,
   output logic [31:0]       rsp_audio_addr,
   output logic [17:0]       rsp_audio_samples
);

   // Captured transaction.
   logic [2:0]  op_ff;
   logic [15:0] offset_ff;
   logic [31:0] data_ff;
   logic [1:0]  source_ff;
   logic        set_ff;

   // Architectural registers and their next values.
   logic [26:0] aux_size_ff;
   logic [15:0] control_ff, control_in;
   logic [15:0] info_ff, info_in;
   logic [15:0] mode_ff, mode_in;
   logic [15:0] refresh_ff, refresh_in;
   logic [31:0] main_addr_ff, main_addr_in;
   logic [31:0] aux_addr_ff, aux_addr_in;
   logic [31:0] count_dir_ff, count_dir_in;
   logic [31:0] audio_source_ff, audio_source_in;
   logic [31:0] audio_read_ff, audio_read_in;
   logic [15:0] audio_ctrl_ff, audio_ctrl_in;
   logic [14:0] blocks_ff, blocks_in;

   // Result registers and their next values.
   logic [31:0] read_data_ff, read_data_in;
   logic        irq_line_ff, irq_line_in;
   logic        dma_start_ff, dma_start_in;
   logic        dma_to_main_ff, dma_to_main_in;
   logic [25:0] dma_main_ff, dma_main_in;
   logic [25:0] dma_aux_ff, dma_aux_in;
   logic [30:0] dma_bytes_ff, dma_bytes_in;
   logic        dma_range_ff, dma_range_in;
   logic        push_ff, push_in;
   logic        silence_ff, silence_in;
   logic [31:0] audio_addr_ff, audio_addr_in;
   logic [17:0] samples_ff, samples_in;

   // Working values for one transaction.
   logic [31:0] wdata16;
   logic        xfer_go;
   logic [31:0] xfer_cd;
   logic [30:0] xfer_count;
   logic [25:0] xfer_main26;
   logic [25:0] xfer_aux26;
   logic [14:0] blocks_dec;
   logic [14:0] nblocks;
   logic [15:0] ctl_tmp;

   assign wdata16     = {16'd0, data_ff[15:0]};
   assign blocks_dec  = blocks_ff - 15'd1;
   assign nblocks     = audio_ctrl_ff[14:0];
   assign xfer_main26 = main_addr_ff[25:0];
   assign xfer_aux26  = aux_addr_ff[25:0];

   // Register updates and the result of the captured transaction.
   always_comb begin
      control_in      = control_ff;
      info_in         = info_ff;
      mode_in         = mode_ff;
      refresh_in      = refresh_ff;
      main_addr_in    = main_addr_ff;
      aux_addr_in     = aux_addr_ff;
      count_dir_in    = count_dir_ff;
      audio_source_in = audio_source_ff;
      audio_read_in   = audio_read_ff;
      audio_ctrl_in   = audio_ctrl_ff;
      blocks_in       = blocks_ff;
      read_data_in    = 32'd0;
      push_in         = 1'b0;
      silence_in      = 1'b0;
      audio_addr_in   = 32'd0;
      samples_in      = 18'd0;
      xfer_go         = 1'b0;
      xfer_cd         = 32'd0;
      ctl_tmp         = 16'd0;

      case (op_ff)
         OP_READ16: begin
            case (offset_ff)
               OFS_CONTROL:    read_data_in = {16'd0, control_ff};
               OFS_INFO:       read_data_in = {16'd0, info_ff};
               OFS_MODE:       read_data_in = {16'd0, mode_ff};
               OFS_REFRESH:    read_data_in = {16'd0, refresh_ff};
               OFS_MAIN_HI:    read_data_in = {16'd0, main_addr_ff[31:16]};
               OFS_MAIN_LO:    read_data_in = {16'd0, main_addr_ff[15:0]};
               OFS_AUX_HI:     read_data_in = {16'd0, aux_addr_ff[31:16]};
               OFS_AUX_LO:     read_data_in = {16'd0, aux_addr_ff[15:0]};
               OFS_COUNT_HI:   read_data_in = {16'd0, count_dir_ff[31:16]};
               OFS_COUNT_LO:   read_data_in = {16'd0, count_dir_ff[15:0]};
               OFS_SOURCE_HI:  read_data_in = {16'd0, audio_source_ff[31:16]};
               OFS_SOURCE_LO:  read_data_in = {16'd0, audio_source_ff[15:0]};
               OFS_AUDIO_CTRL: read_data_in = {16'd0, audio_ctrl_ff};
               OFS_BLOCKS: begin
                  read_data_in = (blocks_ff != 15'd0) ? {17'd0, blocks_dec} : 32'd0;
               end
               default:        read_data_in = 32'd0;
            endcase
         end
         OP_WRITE16: begin
            case (offset_ff)
               OFS_CONTROL: begin
                  if (wdata16[CTL_RESET]) begin
                     audio_ctrl_in = 16'd0;
                  end
                  ctl_tmp    = (control_ff & ~CTL_PLAIN_BITS) |
                               (wdata16[15:0] & CTL_PLAIN_BITS);
                  control_in = ctl_tmp & ~(wdata16[15:0] & CTL_W1C_BITS);
               end
               OFS_INFO:    info_in    = wdata16[15:0];
               OFS_MODE:    mode_in    = wdata16[15:0];
               OFS_REFRESH: refresh_in = wdata16[15:0];
               OFS_MAIN_HI: main_addr_in = {wdata16[15:0], main_addr_ff[15:0]};
               OFS_MAIN_LO: begin
                  main_addr_in = ((main_addr_ff & HI_HALF_MASK) | wdata16) & ALIGN32_MASK;
               end
               OFS_AUX_HI:  aux_addr_in = {wdata16[15:0], aux_addr_ff[15:0]};
               OFS_AUX_LO: begin
                  aux_addr_in = ((aux_addr_ff & HI_HALF_MASK) | wdata16) & ALIGN32_MASK;
               end
               OFS_COUNT_HI: count_dir_in = {wdata16[15:0], count_dir_ff[15:0]};
               OFS_COUNT_LO: begin
                  xfer_go = 1'b1;
                  xfer_cd = ((count_dir_ff & HI_HALF_MASK) | wdata16) & ALIGN32_MASK;
               end
               OFS_SOURCE_HI: audio_source_in = {wdata16[15:0], audio_source_ff[15:0]};
               OFS_SOURCE_LO: audio_source_in = {audio_source_ff[31:16], wdata16[15:0]};
               OFS_AUDIO_CTRL: begin
                  audio_ctrl_in = wdata16[15:0];
                  audio_read_in = audio_source_ff;
                  blocks_in     = wdata16[14:0];
               end
               default: begin
               end
            endcase
         end
         OP_READ32: begin
            case (offset_ff)
               OFS_SOURCE_HI: read_data_in = audio_source_ff;
               OFS_AUX_HI:    read_data_in = aux_addr_ff;
               OFS_COUNT_HI:  read_data_in = count_dir_ff;
               OFS_MAIN_HI:   read_data_in = main_addr_ff;
               default:       read_data_in = 32'd0;
            endcase
         end
         OP_WRITE32: begin
            case (offset_ff)
               OFS_SOURCE_HI: audio_source_in = data_ff;
               OFS_MAIN_HI:   main_addr_in    = data_ff & ALIGN32_MASK;
               OFS_AUX_HI:    aux_addr_in     = data_ff & ALIGN32_MASK;
               OFS_COUNT_HI: begin
                  xfer_go = 1'b1;
                  xfer_cd = data_ff & ALIGN32_MASK;
               end
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            if (audio_ctrl_ff[15] && (blocks_ff != 15'd0)) begin
               blocks_in     = blocks_dec;
               audio_read_in = audio_read_ff + BLOCK_BYTES;
               if (blocks_dec == 15'd0) begin
                  push_in              = 1'b1;
                  audio_addr_in        = audio_source_ff;
                  samples_in           = {nblocks, 3'b000};
                  control_in[CTL_AID]  = 1'b1;
                  blocks_in            = nblocks;
                  audio_read_in        = audio_source_ff;
               end
            end else begin
               silence_in = 1'b1;
            end
         end
         OP_IRQ: begin
            case (source_ff)
               SRC_DSP:  control_in[CTL_DSP] = set_ff;
               SRC_ARAM: begin
                  control_in[CTL_ARAM] = set_ff;
                  if (set_ff) begin
                     control_in[CTL_DMA_BUSY] = 1'b0;
                  end
               end
               SRC_AID:  control_in[CTL_AID] = set_ff;
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // Transfer start: report the request, then advance both addresses.
      xfer_count     = xfer_cd[30:0];
      dma_start_in   = xfer_go;
      dma_to_main_in = xfer_go & xfer_cd[31];
      dma_main_in    = xfer_go ? xfer_main26 : 26'd0;
      dma_aux_in     = xfer_go ? xfer_aux26 : 26'd0;
      dma_bytes_in   = xfer_go ? xfer_count : 31'd0;
      dma_range_in   = xfer_go && ({1'b0, xfer_aux26} < aux_size_ff);
      if (xfer_go) begin
         if (xfer_count == SINGLE_BLOCK) begin
            control_in[CTL_ARAM]     = 1'b1;
            control_in[CTL_DMA_BUSY] = 1'b0;
         end else begin
            control_in[CTL_DMA_BUSY] = 1'b1;
         end
         main_addr_in = {6'd0, xfer_main26} + {1'b0, xfer_count};
         aux_addr_in  = {6'd0, xfer_aux26} + {1'b0, xfer_count};
         count_dir_in = {xfer_cd[31], 31'd0};
      end

      // Interrupt line after the transaction.
      irq_line_in = (control_in[CTL_AID] & control_in[CTL_AID_MASK]) |
                    (control_in[CTL_ARAM] & control_in[CTL_ARAM_MASK]) |
                    (control_in[CTL_DSP] & control_in[CTL_DSP_MASK]);
   end

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         offset_ff <= req_reg_offset;
         data_ff   <= req_write_data;
         source_ff <= req_irq_source;
         set_ff    <= req_irq_set;
      end
   end

   // Architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         aux_size_ff     <= AUX_SIZE_RESET;
         control_ff      <= CONTROL_RESET;
         info_ff         <= INFO_RESET;
         mode_ff         <= MODE_RESET;
         refresh_ff      <= REFRESH_RESET;
         main_addr_ff    <= 32'd0;
         aux_addr_ff     <= 32'd0;
         count_dir_ff    <= 32'd0;
         audio_source_ff <= 32'd0;
         audio_read_ff   <= 32'd0;
         audio_ctrl_ff   <= 16'd0;
         blocks_ff       <= 15'd0;
      end else begin
         if (cfg_write && (cfg_index == CFG_AUX_RAM_SIZE)) begin
            aux_size_ff <= cfg_wdata[26:0];
         end
         if (cmd.commit) begin
            control_ff      <= control_in;
            info_ff         <= info_in;
            mode_ff         <= mode_in;
            refresh_ff      <= refresh_in;
            main_addr_ff    <= main_addr_in;
            aux_addr_ff     <= aux_addr_in;
            count_dir_ff    <= count_dir_in;
            audio_source_ff <= audio_source_in;
            audio_read_ff   <= audio_read_in;
            audio_ctrl_ff   <= audio_ctrl_in;
            blocks_ff       <= blocks_in;
         end
      end
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         read_data_ff   <= read_data_in;
         irq_line_ff    <= irq_line_in;
         dma_start_ff   <= dma_start_in;
         dma_to_main_ff <= dma_to_main_in;
         dma_main_ff    <= dma_main_in;
         dma_aux_ff     <= dma_aux_in;
         dma_bytes_ff   <= dma_bytes_in;
         dma_range_ff   <= dma_range_in;
         push_ff        <= push_in;
         silence_ff     <= silence_in;
         audio_addr_ff  <= audio_addr_in;
         samples_ff     <= samples_in;
      end
   end

   // Configuration readback.
   assign cfg_rdata = (cfg_index == CFG_AUX_RAM_SIZE) ? {5'd0, aux_size_ff} : 32'd0;

   assign rsp_read_data     = read_data_ff;
   assign rsp_irq_line      = irq_line_ff;
   assign rsp_dma_start     = dma_start_ff;
   assign rsp_dma_to_main   = dma_to_main_ff;
   assign rsp_dma_main_addr = dma_main_ff;
   assign rsp_dma_aux_addr  = dma_aux_ff;
   assign rsp_dma_bytes     = dma_bytes_ff;
   assign rsp_dma_in_range  = dma_range_ff;
   assign rsp_audio_push    = push_ff;
   assign rsp_audio_silence = silence_ff;
   assign rsp_audio_addr    = audio_addr_ff;
   assign rsp_audio_samples = samples_ff;

endmodule : adsp_datapath

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Audio DSP interface registers, self-checking testbench
// Feeds bus accesses, audio ticks and interrupt events through the command
// port, and predicts every result with a cycle-free model of the register
// file. Results are compared field by field in arrival order. The auxiliary
// RAM size is reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import adsp_pkg::*;

   localparam int          CLK_PERIOD      = 20;
   localparam int          IDLE_LIMIT      = 2000;
   localparam int          ITEMS_PER_PHASE = 375;
   localparam int          DRAIN_CYCLES    = 4;
   localparam logic [31:0] AUX_SIZE_MASK   = 32'h07FF_FFFF;
   localparam logic [31:0] ADDR26_MASK     = 32'h03FF_FFFF;
   localparam logic [31:0] DIR_BIT_MASK    = 32'h8000_0000;
   localparam logic [2:0]  OP_RSVD6        = 3'd6;
   localparam logic [2:0]  OP_RSVD7        = 3'd7;
   localparam logic [1:0]  SRC_NONE        = 2'd3;
   localparam logic [15:0] OFS_MAILBOX     = 16'h5000;
   localparam logic [15:0] OFS_UNMAPPED    = 16'h0000;

   // One command transaction.
   typedef struct {
      logic [2:0]  op;
      logic [15:0] ofs;
      logic [31:0] data;
      logic [1:0]  src;
      logic        set;
   } bus_item_type;

   // One result transaction.
   typedef struct {
      logic [31:0] read_data;
      logic        irq_line;
      logic        dma_start;
      logic        dma_to_main;
      logic [25:0] dma_main_addr;
      logic [25:0] dma_aux_addr;
      logic [30:0] dma_bytes;
      logic        dma_in_range;
      logic        audio_push;
      logic        audio_silence;
      logic [31:0] audio_addr;
      logic [17:0] audio_samples;
   } dsp_result_type;

   // Clock, reset and block ports.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [15:0] req_reg_offset = '0;
   logic [31:0] req_write_data = '0;
   logic [1:0]  req_irq_source = '0;
   logic        req_irq_set = 1'b0;
   logic        rsp_valid;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_line;
   logic        rsp_dma_start;
   logic        rsp_dma_to_main;
   logic [25:0] rsp_dma_main_addr;
   logic [25:0] rsp_dma_aux_addr;
   logic [30:0] rsp_dma_bytes;
   logic        rsp_dma_in_range;
   logic        rsp_audio_push;
   logic        rsp_audio_silence;
   logic [31:0] rsp_audio_addr;
   logic [17:0] rsp_audio_samples;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Shadow copy of the register file.
   logic [26:0] aux_size;
   logic [15:0] ctl_reg;
   logic [15:0] ar_info;
   logic [15:0] ar_mode;
   logic [15:0] refresh_period;
   logic [31:0] main_addr;
   logic [31:0] aux_addr;
   logic [31:0] count_dir;
   logic [31:0] play_source;
   logic [15:0] play_ctrl;
   logic [14:0] blocks_left;

   // Pending commands, predicted results and bookkeeping.
   bus_item_type   pending_cmds[$];
   dsp_result_type expected_results[$];
   int             sent_cnt = 0;
   int             taken_cnt = 0;
   int             gap_left = 0;
   int             burst_left = 0;
   int             idle_cycles = 0;
   int             err_cnt = 0;
   int             xfer_cnt = 0;
   int             push_cnt = 0;
   int             silence_cnt = 0;
   int             size_settings = 1;

   logic [15:0] reg_offsets[14] = '{OFS_CONTROL, OFS_INFO, OFS_MODE, OFS_REFRESH,
                                    OFS_MAIN_HI, OFS_MAIN_LO, OFS_AUX_HI, OFS_AUX_LO,
                                    OFS_COUNT_HI, OFS_COUNT_LO, OFS_SOURCE_HI,
                                    OFS_SOURCE_LO, OFS_AUDIO_CTRL, OFS_BLOCKS};

   audio_dsp_interface_registers_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_reg_offset    (req_reg_offset),
      .req_write_data    (req_write_data),
      .req_irq_source    (req_irq_source),
      .req_irq_set       (req_irq_set),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_irq_line      (rsp_irq_line),
      .rsp_dma_start     (rsp_dma_start),
      .rsp_dma_to_main   (rsp_dma_to_main),
      .rsp_dma_main_addr (rsp_dma_main_addr),
      .rsp_dma_aux_addr  (rsp_dma_aux_addr),
      .rsp_dma_bytes     (rsp_dma_bytes),
      .rsp_dma_in_range  (rsp_dma_in_range),
      .rsp_audio_push    (rsp_audio_push),
      .rsp_audio_silence (rsp_audio_silence),
      .rsp_audio_addr    (rsp_audio_addr),
      .rsp_audio_samples (rsp_audio_samples),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // Free-running clock.
   always #(CLK_PERIOD / 2) clock = ~clock;

   // Reset the shadow registers to their power-up values.
   task automatic reset_shadow();
      aux_size       = AUX_SIZE_RESET;
      ctl_reg        = CONTROL_RESET;
      ar_info        = INFO_RESET;
      ar_mode        = MODE_RESET;
      refresh_period = REFRESH_RESET;
      main_addr      = '0;
      aux_addr       = '0;
      count_dir      = '0;
      play_source    = '0;
      play_ctrl      = '0;
      blocks_left    = '0;
   endtask

   // Start an auxiliary RAM transfer from the current address and count.
   task automatic launch_transfer(inout dsp_result_type res);
      logic [30:0] nbytes;
      nbytes = count_dir[30:0];
      if (nbytes == SINGLE_BLOCK) begin
         ctl_reg[CTL_ARAM]     = 1'b1;
         ctl_reg[CTL_DMA_BUSY] = 1'b0;
      end else begin
         ctl_reg[CTL_DMA_BUSY] = 1'b1;
      end
      main_addr         = main_addr & ADDR26_MASK;
      aux_addr          = aux_addr & ADDR26_MASK;
      res.dma_start     = 1'b1;
      res.dma_to_main   = count_dir[31];
      res.dma_main_addr = main_addr[25:0];
      res.dma_aux_addr  = aux_addr[25:0];
      res.dma_bytes     = nbytes;
      res.dma_in_range  = (aux_addr < {5'b0, aux_size});
      main_addr         = main_addr + {1'b0, nbytes};
      aux_addr          = aux_addr + {1'b0, nbytes};
      count_dir         = count_dir & DIR_BIT_MASK;
      xfer_cnt++;
   endtask

   // Compute the result of one transaction and advance the shadow state.
   task automatic predict_result(input bus_item_type it, output dsp_result_type res);
      logic [31:0] v16;
      logic [15:0] plain;
      logic [14:0] nblocks;
      res  = '{default: '0};
      v16  = {16'b0, it.data[15:0]};
      case (it.op)
         OP_READ16: begin
            case (it.ofs)
               OFS_CONTROL:    res.read_data = {16'b0, ctl_reg};
               OFS_INFO:       res.read_data = {16'b0, ar_info};
               OFS_MODE:       res.read_data = {16'b0, ar_mode};
               OFS_REFRESH:    res.read_data = {16'b0, refresh_period};
               OFS_MAIN_HI:    res.read_data = {16'b0, main_addr[31:16]};
               OFS_MAIN_LO:    res.read_data = {16'b0, main_addr[15:0]};
               OFS_AUX_HI:     res.read_data = {16'b0, aux_addr[31:16]};
               OFS_AUX_LO:     res.read_data = {16'b0, aux_addr[15:0]};
               OFS_COUNT_HI:   res.read_data = {16'b0, count_dir[31:16]};
               OFS_COUNT_LO:   res.read_data = {16'b0, count_dir[15:0]};
               OFS_SOURCE_HI:  res.read_data = {16'b0, play_source[31:16]};
               OFS_SOURCE_LO:  res.read_data = {16'b0, play_source[15:0]};
               OFS_AUDIO_CTRL: res.read_data = {16'b0, play_ctrl};
               OFS_BLOCKS:     res.read_data = (blocks_left != 0) ?
                                               {17'b0, blocks_left - 15'd1} : 32'd0;
               default:        res.read_data = '0;
            endcase
         end
         OP_WRITE16: begin
            case (it.ofs)
               OFS_CONTROL: begin
                  // Plain bits follow the write, flags clear on a one, busy is kept.
                  if (v16[CTL_RESET]) play_ctrl = '0;
                  plain   = CTL_PLAIN_BITS;
                  ctl_reg = (ctl_reg & ~plain) | (v16[15:0] & plain);
                  ctl_reg = ctl_reg & ~(v16[15:0] & CTL_W1C_BITS);
               end
               OFS_INFO:      ar_info = v16[15:0];
               OFS_MODE:      ar_mode = v16[15:0];
               OFS_REFRESH:   refresh_period = v16[15:0];
               OFS_MAIN_HI:   main_addr = {v16[15:0], main_addr[15:0]};
               OFS_MAIN_LO:   main_addr = ((main_addr & HI_HALF_MASK) | v16) & ALIGN32_MASK;
               OFS_AUX_HI:    aux_addr = {v16[15:0], aux_addr[15:0]};
               OFS_AUX_LO:    aux_addr = ((aux_addr & HI_HALF_MASK) | v16) & ALIGN32_MASK;
               OFS_COUNT_HI:  count_dir = {v16[15:0], count_dir[15:0]};
               OFS_COUNT_LO: begin
                  count_dir = ((count_dir & HI_HALF_MASK) | v16) & ALIGN32_MASK;
                  launch_transfer(res);
               end
               OFS_SOURCE_HI: play_source = {v16[15:0], play_source[15:0]};
               OFS_SOURCE_LO: play_source = {play_source[31:16], v16[15:0]};
               OFS_AUDIO_CTRL: begin
                  play_ctrl   = v16[15:0];
                  blocks_left = v16[14:0];
               end
               default: ;
            endcase
         end
         OP_READ32: begin
            case (it.ofs)
               OFS_SOURCE_HI: res.read_data = play_source;
               OFS_AUX_HI:    res.read_data = aux_addr;
               OFS_COUNT_HI:  res.read_data = count_dir;
               OFS_MAIN_HI:   res.read_data = main_addr;
               default:       res.read_data = '0;
            endcase
         end
         OP_WRITE32: begin
            case (it.ofs)
               OFS_SOURCE_HI: play_source = it.data;
               OFS_MAIN_HI:   main_addr = it.data & ALIGN32_MASK;
               OFS_AUX_HI:    aux_addr = it.data & ALIGN32_MASK;
               OFS_COUNT_HI: begin
                  count_dir = it.data & ALIGN32_MASK;
                  launch_transfer(res);
               end
               default: ;
            endcase
         end
         OP_TICK: begin
            // Count down one block; the last one hands out the buffer and reloads.
            nblocks = play_ctrl[14:0];
            if (play_ctrl[15] && blocks_left != 0) begin
               blocks_left = blocks_left - 15'd1;
               if (blocks_left == 0) begin
                  res.audio_push    = 1'b1;
                  res.audio_addr    = play_source;
                  res.audio_samples = {nblocks, 3'b000};
                  ctl_reg[CTL_AID]  = 1'b1;
                  blocks_left       = nblocks;
                  push_cnt++;
               end
            end else begin
               res.audio_silence = 1'b1;
               silence_cnt++;
            end
         end
         OP_IRQ: begin
            case (it.src)
               SRC_DSP:  ctl_reg[CTL_DSP] = it.set;
               SRC_ARAM: begin
                  ctl_reg[CTL_ARAM] = it.set;
                  if (it.set) ctl_reg[CTL_DMA_BUSY] = 1'b0;
               end
               SRC_AID:  ctl_reg[CTL_AID] = it.set;
               default: ;
            endcase
         end
         default: ;
      endcase
      res.irq_line = (ctl_reg[CTL_AID] & ctl_reg[CTL_AID_MASK]) |
                     (ctl_reg[CTL_ARAM] & ctl_reg[CTL_ARAM_MASK]) |
                     (ctl_reg[CTL_DSP] & ctl_reg[CTL_DSP_MASK]);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         err_cnt++;
      end
   endtask

   // Command driver: holds each transaction until accepted, then idles a while.
   always @(negedge clock) begin
      bus_item_type it;
      if (reset) begin
         start <= 1'b0;
      end else if (start && taken_cnt != sent_cnt) begin
         // Still waiting for the block to take the current transaction.
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (pending_cmds.size() > 0) begin
         it = pending_cmds.pop_front();
         req_operation  <= it.op;
         req_reg_offset <= it.ofs;
         req_write_data <= it.data;
         req_irq_source <= it.src;
         req_irq_set    <= it.set;
         start          <= 1'b1;
         sent_cnt++;
         gap_left = pick_gap();
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: checks results, predicts accepted transactions, tracks activity.
   always @(posedge clock) begin
      dsp_result_type want;
      bus_item_type   it;
      logic           accepted;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no pending expectation");
               err_cnt++;
            end else begin
               want = expected_results.pop_front();
               check_field("read_data", want.read_data, rsp_read_data);
               check_field("irq_line", 32'(want.irq_line), 32'(rsp_irq_line));
               check_field("dma_start", 32'(want.dma_start), 32'(rsp_dma_start));
               check_field("dma_to_main", 32'(want.dma_to_main), 32'(rsp_dma_to_main));
               check_field("dma_main_addr", 32'(want.dma_main_addr),
                           32'(rsp_dma_main_addr));
               check_field("dma_aux_addr", 32'(want.dma_aux_addr), 32'(rsp_dma_aux_addr));
               check_field("dma_bytes", 32'(want.dma_bytes), 32'(rsp_dma_bytes));
               check_field("dma_in_range", 32'(want.dma_in_range), 32'(rsp_dma_in_range));
               check_field("audio_push", 32'(want.audio_push), 32'(rsp_audio_push));
               check_field("audio_silence", 32'(want.audio_silence),
                           32'(rsp_audio_silence));
               check_field("audio_addr", want.audio_addr, rsp_audio_addr);
               check_field("audio_samples", 32'(want.audio_samples),
                           32'(rsp_audio_samples));
            end
         end
         accepted = start && !busy;
         if (accepted) begin
            it.op   = req_operation;
            it.ofs  = req_reg_offset;
            it.data = req_write_data;
            it.src  = req_irq_source;
            it.set  = req_irq_set;
            predict_result(it, want);
            expected_results.push_back(want);
            taken_cnt <= taken_cnt + 1;
         end
         idle_cycles <= (accepted || rsp_valid) ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog on a stalled run.
   initial begin
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $error("no transaction for %0d cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Idle gap after a transaction: mostly short, a few long, with bursts of none.
   function automatic int pick_gap();
      int unsigned r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom & ADDR26_MASK;
         2:       return $urandom & 32'h00FF_FFFF;
         default: return $urandom & 32'h0000_03FF;
      endcase
   endfunction

   function automatic logic [31:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30) return BLOCK_BYTES;
      if (r < 40) return 32'd0;
      if (r < 80) return BLOCK_BYTES * $urandom_range(2, 64);
      return $urandom;
   endfunction

   task automatic add_item(input logic [2:0] op, input logic [15:0] ofs,
                           input logic [31:0] data, input logic [1:0] src,
                           input logic set);
      bus_item_type it;
      it.op   = op;
      it.ofs  = ofs;
      it.data = data;
      it.src  = src;
      it.set  = set;
      pending_cmds.push_back(it);
   endtask

   // Bus access with random don't-care interrupt fields.
   task automatic add_access(input logic [2:0] op, input logic [15:0] ofs,
                             input logic [31:0] data);
      add_item(op, ofs, data, 2'($urandom), 1'($urandom));
   endtask

   // Write a 32-bit value either in one access or as two 16-bit halves.
   task automatic add_split_write(input logic [15:0] hi_ofs, input logic [15:0] lo_ofs,
                                  input logic [31:0] v);
      if ($urandom_range(0, 1)) begin
         add_access(OP_WRITE32, hi_ofs, v);
      end else begin
         add_access(OP_WRITE16, hi_ofs, {16'($urandom), v[31:16]});
         add_access(OP_WRITE16, lo_ofs, {16'($urandom), v[15:0]});
      end
   endtask

   // One random stimulus element: mostly well-formed sequences, some noise.
   task automatic add_random_item();
      int unsigned r;
      int unsigned n;
      logic [31:0] v;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         // Full transfer setup: main address, aux address, count with direction.
         add_split_write(OFS_MAIN_HI, OFS_MAIN_LO, pick_addr());
         add_split_write(OFS_AUX_HI, OFS_AUX_LO, pick_addr());
         v = pick_count();
         v[31] = 1'($urandom);
         add_split_write(OFS_COUNT_HI, OFS_COUNT_LO, v);
         if ($urandom_range(0, 1)) add_access(OP_READ16, OFS_CONTROL, $urandom);
      end else if (r < 20) begin
         // Audio playback setup followed by a few ticks.
         if ($urandom_range(0, 1)) add_access(OP_WRITE32, OFS_SOURCE_HI, $urandom);
         else add_access(OP_WRITE16, OFS_SOURCE_LO, $urandom);
         v = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 4);
         v[15] = ($urandom_range(0, 9) != 0);
         add_access(OP_WRITE16, OFS_AUDIO_CTRL, {16'($urandom), v[15:0]});
         n = $urandom_range(1, 6);
         repeat (n) add_access(OP_TICK, 16'($urandom), $urandom);
      end else if (r < 38) begin
         add_access(OP_TICK, 16'($urandom), $urandom);
      end else if (r < 55) begin
         add_access($urandom_range(0, 1) ? OP_WRITE16 : OP_WRITE32,
                    reg_offsets[$urandom_range(0, 13)], $urandom);
      end else if (r < 75) begin
         add_access($urandom_range(0, 1) ? OP_READ16 : OP_READ32,
                    reg_offsets[$urandom_range(0, 13)], $urandom);
      end else if (r < 87) begin
         add_item(OP_IRQ, 16'($urandom), $urandom, 2'($urandom), 1'($urandom));
      end else begin
         add_item(3'($urandom), 16'($urandom), $urandom, 2'($urandom), 1'($urandom));
      end
   endtask

   // Wait until every transaction is accepted and every result has arrived.
   task automatic drain();
      while (pending_cmds.size() != 0 || taken_cnt != sent_cnt ||
             expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Program the auxiliary RAM size and read it back.
   task automatic write_aux_size(input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CFG_AUX_RAM_SIZE, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (value & AUX_SIZE_MASK)) begin
         $error("aux_ram_size: expected 0x%0h, got 0x%0h", value & AUX_SIZE_MASK, prdata);
         err_cnt++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      aux_size = value[26:0];
   endtask

   // Main sequence.
   initial begin
      logic [31:0] sizes[4];
      reset_shadow();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the power-up size.
      add_access(OP_READ16, OFS_CONTROL, '0);
      add_access(OP_WRITE16, OFS_CONTROL, 32'hFFFF_0150);
      add_access(OP_WRITE16, OFS_INFO, 32'h0000_FFFF);
      add_access(OP_WRITE32, OFS_MAIN_HI, 32'hFFFF_FFFF);
      add_access(OP_WRITE32, OFS_AUX_HI, 32'h00FF_FFE0);
      add_access(OP_WRITE16, OFS_COUNT_HI, 32'h0000_8000);
      // A single 32-byte block raises the ARAM flag at once.
      add_access(OP_WRITE16, OFS_COUNT_LO, 32'h0000_003F);
      add_access(OP_READ32, OFS_MAIN_HI, '0);
      add_access(OP_WRITE16, OFS_CONTROL, 32'h0000_01F0);
      // A zero count leaves the busy bit set until an ARAM event.
      add_access(OP_WRITE32, OFS_COUNT_HI, 32'h0000_0000);
      add_item(OP_IRQ, OFS_UNMAPPED, '0, SRC_ARAM, 1'b1);
      // The largest count makes both addresses wrap.
      add_access(OP_WRITE32, OFS_COUNT_HI, 32'hFFFF_FFFF);
      add_access(OP_READ32, OFS_AUX_HI, '0);
      add_item(OP_IRQ, OFS_UNMAPPED, '0, SRC_NONE, 1'b1);
      add_item(OP_IRQ, OFS_UNMAPPED, '0, SRC_DSP, 1'b1);
      add_item(OP_IRQ, OFS_UNMAPPED, '0, SRC_DSP, 1'b0);
      add_access(OP_WRITE32, OFS_SOURCE_HI, 32'h8000_1234);
      add_access(OP_WRITE16, OFS_AUDIO_CTRL, 32'h0000_8002);
      add_access(OP_TICK, OFS_UNMAPPED, '0);
      add_access(OP_TICK, OFS_UNMAPPED, '0);
      add_access(OP_READ16, OFS_BLOCKS, '0);
      // The reset bit of a control write also stops the audio DMA.
      add_access(OP_WRITE16, OFS_CONTROL, 32'h0000_0001);
      add_access(OP_TICK, OFS_UNMAPPED, '0);
      add_access(OP_RSVD6, OFS_CONTROL, 32'hFFFF_FFFF);
      add_access(OP_RSVD7, OFS_CONTROL, 32'hFFFF_FFFF);
      add_access(OP_READ16, OFS_UNMAPPED, '0);
      add_access(OP_WRITE16, OFS_MAILBOX, 32'h0000_FFFF);
      drain();

      // Random phases, one per auxiliary RAM size.
      sizes = '{32'd0, 32'd67108864, 32'($urandom_range(1, 67108863)), 32'd16777216};
      foreach (sizes[i]) begin
         write_aux_size(sizes[i]);
         size_settings++;
         while (pending_cmds.size() < ITEMS_PER_PHASE) add_random_item();
         drain();
      end

      $display("Ran %0d transactions over %0d aux RAM size settings.",
               taken_cnt, size_settings);
      $display("Saw %0d DMA transfers, %0d audio buffer pushes, %0d silence ticks.",
               xfer_cnt, push_cnt, silence_cnt);
      if (err_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
